>>> hdl/tcf_pkg.sv
// Shared types, constants and the arctangent table for the tilt complementary filter.
`timescale 1ns / 1ps
`default_nettype none

package tcf_pkg;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL_GYRO,
        S_CORDIC,
        S_ROUND,
        S_MUL_K,
        S_MUL_ACC,
        S_DONE
    } tcf_state_t;

    // Configuration register indexes
    typedef enum logic {
        REG_FILTER_K  = 1'b0,
        REG_GYRO_GAIN = 1'b1
    } tcf_reg_t;

    localparam int TABLE_LEN = 24;
    localparam int TAB_IDX_W = 5;
    localparam int ATAN_W    = 22;
    localparam int HALF_TURN = 180;

    // CORDIC datapath width: scaled inputs plus gain growth, and angle in 1/65536 degree
    localparam int CW     = 26;
    localparam int AW     = 17;     // accel angle
    localparam int ANGW   = 24;     // filtered and gyro angle
    localparam int INCW   = 17;     // gyro increment
    localparam int PATHW  = 25;     // previous angle plus increment
    localparam int KW     = 17;     // filter weight
    localparam int GAINW  = 16;
    localparam int MBW    = 18;     // multiplier second operand
    localparam int PRODW  = PATHW + MBW;
    localparam int SUMW   = PRODW + 1;

    localparam logic [KW-1:0] K_ONE   = KW'(65536);
    localparam logic [KW-1:0] K_RESET = KW'(64225);

    localparam logic signed [CW-1:0] Z_HALF   = CW'(HALF_TURN * 65536);
    localparam logic signed [CW-1:0] ACC_LIM  = CW'(HALF_TURN * 256);

    // atan(2^-i) in 1/65536 degree
    function automatic logic [ATAN_W-1:0] atan_entry(input logic [TAB_IDX_W-1:0] idx);
        logic [ATAN_W-1:0] v;
        unique case (idx)
            5'd0:    v = 22'd2949120;
            5'd1:    v = 22'd1740967;
            5'd2:    v = 22'd919879;
            5'd3:    v = 22'd466945;
            5'd4:    v = 22'd234379;
            5'd5:    v = 22'd117304;
            5'd6:    v = 22'd58666;
            5'd7:    v = 22'd29335;
            5'd8:    v = 22'd14668;
            5'd9:    v = 22'd7334;
            5'd10:   v = 22'd3667;
            5'd11:   v = 22'd1833;
            5'd12:   v = 22'd917;
            5'd13:   v = 22'd458;
            5'd14:   v = 22'd229;
            5'd15:   v = 22'd115;
            5'd16:   v = 22'd57;
            5'd17:   v = 22'd29;
            5'd18:   v = 22'd14;
            5'd19:   v = 22'd7;
            5'd20:   v = 22'd4;
            5'd21:   v = 22'd2;
            5'd22:   v = 22'd1;
            default: v = 22'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

>>> hdl/tilt_complementary_filter.sv
// Top level of the tilt complementary filter: CORDIC tilt, gyro integral and blend.
//
// Usage: one item on the input channel (in_valid/in_ready) carries one IMU
// sample: accel_x, accel_z and gyro_rate. Each item gives exactly one result
// item on the output channel (out_valid/out_ready): filtered_angle,
// accel_angle and gyro_tilt, all in 1/256 degree.
// The config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes
// filter_k (index 0) and gyro_step_gain (index 1); it is always ready and
// should be used only while the block is idle.
// Sequence: an accepted item passes through S_MUL_GYRO, S_CORDIC (CORDIC_STEPS
// rotations, capped at 24 steps), S_ROUND, S_MUL_K, S_MUL_ACC and S_DONE.
// in_ready returns in the cycle the result appears, so no new item is taken
// while one is in flight. The work is done by the single shared
// CORDIC stage, one rotation a cycle, plus three passes through the one
// shared multiplier and a final add.
// Reset: filter_k = 64225, gyro_step_gain = 0, both angles zero, no result.
// Stall: the result sits in an output register; the next item is taken
// meanwhile, and its finished result waits in the sequencer until the
// output register is free.
`timescale 1ns / 1ps
`default_nettype none

module tilt_complementary_filter
    import tcf_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    // config write channel
    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire logic                    cfg_index,
    input  wire logic [KW-1:0]           cfg_data,
    // input channel
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic signed [15:0]      accel_x,
    input  wire logic signed [15:0]      accel_z,
    input  wire logic signed [15:0]      gyro_rate,
    // output channel
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic signed [ANGW-1:0]       filtered_angle,
    output logic signed [AW-1:0]         accel_angle,
    output logic signed [ANGW-1:0]       gyro_tilt
);

    localparam int ITERS  = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
    localparam int ITER_W = (ITERS > 1) ? $clog2(ITERS) : 1;

    localparam logic signed [SUMW-1:0]  BL_MAX = SUMW'(8388607);
    localparam logic signed [SUMW-1:0]  BL_MIN = -SUMW'(8388608);
    localparam logic signed [PATHW-1:0] IN_MAX = PATHW'(8388607);
    localparam logic signed [PATHW-1:0] IN_MIN = -PATHW'(8388608);

    tcf_state_t state_reg, state_next;
    logic [ITER_W-1:0]        iter_reg, iter_next;
    logic signed [CW-1:0]     x_reg, x_next, y_reg, y_next, z_reg, z_next;
    logic                     zero_reg, zero_next;
    logic signed [15:0]       rate_reg, rate_next;
    logic signed [INCW-1:0]   inc_reg, inc_next;
    logic signed [AW-1:0]     acc_reg, acc_next;
    logic signed [PATHW-1:0]  path_reg, path_next;
    logic signed [PRODW-1:0]  prod_reg, prod_next;
    logic signed [PRODW-1:0]  mix_reg, mix_next;
    logic signed [ANGW-1:0]   blended_reg, blended_next;
    logic signed [ANGW-1:0]   integ_reg, integ_next;
    logic [KW-1:0]            filter_k_reg;
    logic [GAINW-1:0]         gain_reg;
    logic                     out_valid_reg, out_valid_next;
    logic signed [ANGW-1:0]   out_filt_reg, out_filt_next;
    logic signed [AW-1:0]     out_acc_reg, out_acc_next;
    logic signed [ANGW-1:0]   out_gyro_reg, out_gyro_next;

    // shared multiplier
    logic signed [PATHW-1:0]  mul_a;
    logic signed [MBW-1:0]    mul_b;
    logic signed [PRODW-1:0]  mul_p;

    logic [KW-1:0]            k_eff, k_comp;
    logic signed [CW-1:0]     ax_s, az_s, x_sh, y_sh, atan_v, z_rnd;
    logic signed [PRODW-1:0]  inc_full;
    logic signed [SUMW-1:0]   blend_sum, blend_sh;
    logic signed [PATHW-1:0]  integ_sum;
    logic                     out_free;

    // clamp weight to 1.0
    assign k_eff  = (filter_k_reg > K_ONE) ? K_ONE : filter_k_reg;
    assign k_comp = K_ONE - k_eff;

    assign ax_s = {{(CW-24){accel_x[15]}}, accel_x, 8'd0};
    assign az_s = {{(CW-24){accel_z[15]}}, accel_z, 8'd0};

    // one CORDIC rotation per cycle
    assign x_sh   = x_reg >>> iter_reg;
    assign y_sh   = y_reg >>> iter_reg;
    assign atan_v = $signed({{(CW-ATAN_W){1'b0}}, atan_entry(TAB_IDX_W'(iter_reg))});

    assign z_rnd     = (z_reg + CW'(128)) >>> 8;
    assign inc_full  = (prod_reg + PRODW'(32768)) >>> 16;
    assign blend_sum = SUMW'(mix_reg) + SUMW'(prod_reg) + SUMW'(32768);
    assign blend_sh  = blend_sum >>> 16;
    assign integ_sum = PATHW'(integ_reg) + PATHW'(inc_reg);
    assign out_free  = !out_valid_reg || out_ready;

    // select multiplier operands by state
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_MUL_GYRO:
            begin
                mul_a = PATHW'(rate_reg);
                mul_b = $signed({{(MBW-GAINW){1'b0}}, gain_reg});
            end
            S_MUL_K:
            begin
                mul_a = path_reg;
                mul_b = $signed({{(MBW-KW){1'b0}}, k_eff});
            end
            S_MUL_ACC:
            begin
                mul_a = PATHW'(acc_reg);
                mul_b = $signed({{(MBW-KW){1'b0}}, k_comp});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // sequencer: next state and datapath
    always_comb
    begin
        state_next     = state_reg;
        iter_next      = iter_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        z_next         = z_reg;
        zero_next      = zero_reg;
        rate_next      = rate_reg;
        inc_next       = inc_reg;
        acc_next       = acc_reg;
        path_next      = path_reg;
        prod_next      = prod_reg;
        mix_next       = mix_reg;
        blended_next   = blended_reg;
        integ_next     = integ_reg;
        out_valid_next = out_valid_reg;
        out_filt_next  = out_filt_reg;
        out_acc_next   = out_acc_reg;
        out_gyro_next  = out_gyro_reg;
        in_ready       = 1'b0;

        // drop the result once taken
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    // pre-rotate into the right half plane
                    zero_next = (accel_x == 16'sd0) && (accel_z == 16'sd0);
                    rate_next = gyro_rate;
                    iter_next = '0;
                    if (accel_z < 16'sd0)
                    begin
                        x_next = -az_s;
                        y_next = -ax_s;
                        z_next = (accel_x >= 16'sd0) ? Z_HALF : -Z_HALF;
                    end
                    else
                    begin
                        x_next = az_s;
                        y_next = ax_s;
                        z_next = '0;
                    end
                    state_next = S_MUL_GYRO;
                end
            end
            S_MUL_GYRO:
            begin
                prod_next  = mul_p;
                state_next = S_CORDIC;
            end
            S_CORDIC:
            begin
                inc_next = inc_full[INCW-1:0];
                if (y_reg >= 0)
                begin
                    x_next = x_reg + y_sh;
                    y_next = y_reg - x_sh;
                    z_next = z_reg + atan_v;
                end
                else
                begin
                    x_next = x_reg - y_sh;
                    y_next = y_reg + x_sh;
                    z_next = z_reg - atan_v;
                end
                iter_next = iter_reg + 1'b1;
                if (iter_reg == ITER_W'(ITERS - 1))
                begin
                    state_next = S_ROUND;
                end
            end
            S_ROUND:
            begin
                // round to 1/256 degree and clamp
                if (zero_reg)
                    acc_next = '0;
                else if (z_rnd > ACC_LIM)
                    acc_next = ACC_LIM[AW-1:0];
                else if (z_rnd < -ACC_LIM)
                    acc_next = AW'(-ACC_LIM);
                else
                    acc_next = z_rnd[AW-1:0];
                path_next  = PATHW'(blended_reg) + PATHW'(inc_reg);
                state_next = S_MUL_K;
            end
            S_MUL_K:
            begin
                prod_next  = mul_p;
                state_next = S_MUL_ACC;
            end
            S_MUL_ACC:
            begin
                mix_next   = prod_reg;
                prod_next  = mul_p;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                // hold until the output register is free
                if (out_free)
                begin
                    if (blend_sh > BL_MAX)
                        blended_next = BL_MAX[ANGW-1:0];
                    else if (blend_sh < BL_MIN)
                        blended_next = BL_MIN[ANGW-1:0];
                    else
                        blended_next = blend_sh[ANGW-1:0];
                    if (integ_sum > IN_MAX)
                        integ_next = IN_MAX[ANGW-1:0];
                    else if (integ_sum < IN_MIN)
                        integ_next = IN_MIN[ANGW-1:0];
                    else
                        integ_next = integ_sum[ANGW-1:0];
                    out_valid_next = 1'b1;
                    out_filt_next  = blended_next;
                    out_acc_next   = acc_reg;
                    out_gyro_next  = integ_next;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            iter_reg      <= '0;
            blended_reg   <= '0;
            integ_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            iter_reg      <= iter_next;
            blended_reg   <= blended_next;
            integ_reg     <= integ_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        x_reg        <= x_next;
        y_reg        <= y_next;
        z_reg        <= z_next;
        zero_reg     <= zero_next;
        rate_reg     <= rate_next;
        inc_reg      <= inc_next;
        acc_reg      <= acc_next;
        path_reg     <= path_next;
        prod_reg     <= prod_next;
        mix_reg      <= mix_next;
        out_filt_reg <= out_filt_next;
        out_acc_reg  <= out_acc_next;
        out_gyro_reg <= out_gyro_next;
    end

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_k_reg <= K_RESET;
            gain_reg     <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (tcf_reg_t'(cfg_index))
                REG_FILTER_K:  filter_k_reg <= cfg_data;
                REG_GYRO_GAIN: gain_reg     <= cfg_data[GAINW-1:0];
                default:       gain_reg     <= gain_reg;
            endcase
        end
    end

    assign out_valid      = out_valid_reg;
    assign filtered_angle = out_filt_reg;
    assign accel_angle    = out_acc_reg;
    assign gyro_tilt      = out_gyro_reg;

    // checks
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input accepted while a sample is in flight");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == S_DONE))
        else $error("result appeared without finishing a sample");

    a_accel_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (accel_angle <= AW'(46080)) && (accel_angle >= -AW'(46080)))
        else $error("accel angle out of range");

    a_iter_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CORDIC) |-> (iter_reg <= ITER_W'(ITERS - 1)))
        else $error("CORDIC step count overran");

    a_hold_unfree: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && out_valid && !out_ready) |=> (state_reg == S_DONE))
        else $error("result lost while receiver stalled");

endmodule

`default_nettype wire

>>> tb/sv/tb_tilt_complementary_filter.sv
// Self-checking testbench for the tilt complementary filter: directed, random and saturation items.
`timescale 1ns / 1ps

module tb_tilt_complementary_filter;
    import tcf_pkg::*;

    localparam int     STEPS      = 16;
    localparam int     LATENCY    = STEPS + 5;
    localparam int     MAX_CYCLES = 500000;
    localparam longint ANGLE_HI   = 8388607;
    localparam longint ANGLE_LO   = -8388608;
    localparam longint TILT_LIM   = HALF_TURN * 256;

    typedef struct {
        logic signed [ANGW-1:0] filtered;
        logic signed [AW-1:0]   accel;
        logic signed [ANGW-1:0] gyro;
    } tilt_result_t;

    logic                   clk        = 1'b0;
    logic                   rst_n      = 1'b0;
    logic                   cfg_valid  = 1'b0;
    logic                   cfg_ready;
    logic                   cfg_index  = 1'b0;
    logic [KW-1:0]          cfg_data   = '0;
    logic                   in_valid   = 1'b0;
    logic                   in_ready;
    logic signed [15:0]     accel_x    = '0;
    logic signed [15:0]     accel_z    = '0;
    logic signed [15:0]     gyro_rate  = '0;
    logic                   out_valid;
    logic                   out_ready  = 1'b0;
    logic signed [ANGW-1:0] filtered_angle;
    logic signed [AW-1:0]   accel_angle;
    logic signed [ANGW-1:0] gyro_tilt;

    // Predictor state: registers and the two kept angles
    logic [KW-1:0]    weight_k  = K_RESET;
    logic [GAINW-1:0] step_gain = '0;
    longint           tilt_est  = 0;
    longint           gyro_sum  = 0;

    tilt_result_t expected_q[$];
    int           error_count   = 0;
    int           cycle_count   = 0;
    int           in_gap_pct    = 0;
    int           out_stall_pct = 0;

    tilt_complementary_filter #(
        .CORDIC_STEPS(STEPS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .accel_x       (accel_x),
        .accel_z       (accel_z),
        .gyro_rate     (gyro_rate),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .filtered_angle(filtered_angle),
        .accel_angle   (accel_angle),
        .gyro_tilt     (gyro_tilt)
    );

    always #5 clk = ~clk;

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= MAX_CYCLES)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // atan(2^-i) in 1/65536 degree
    function automatic longint atan_step(input int i);
        longint v;
        case (i)
            0:  v = 2949120;
            1:  v = 1740967;
            2:  v = 919879;
            3:  v = 466945;
            4:  v = 234379;
            5:  v = 117304;
            6:  v = 58666;
            7:  v = 29335;
            8:  v = 14668;
            9:  v = 7334;
            10: v = 3667;
            11: v = 1833;
            12: v = 917;
            13: v = 458;
            14: v = 229;
            15: v = 115;
            16: v = 57;
            17: v = 29;
            18: v = 14;
            19: v = 7;
            20: v = 4;
            21: v = 2;
            22: v = 1;
            default: v = 0;
        endcase
        return v;
    endfunction

    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Vectoring CORDIC for atan2(ax, az), result in 1/256 degree
    function automatic longint accel_tilt(input longint ax, input longint az);
        longint x;
        longint y;
        longint z;
        longint nx;
        int     i;
        x = az * 256;
        y = ax * 256;
        z = 0;
        if (ax == 0 && az == 0)
            return 0;
        // fold the left half-plane over, starting from a half turn
        if (x < 0)
        begin
            z = (y >= 0) ? longint'(HALF_TURN) * 65536 : -longint'(HALF_TURN) * 65536;
            x = -x;
            y = -y;
        end
        for (i = 0; i < STEPS && i < TABLE_LEN; i++)
        begin
            if (y >= 0)
            begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z  = z + atan_step(i);
            end
            else
            begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z  = z - atan_step(i);
            end
            x = nx;
        end
        return clamp((z + 128) >>> 8, -TILT_LIM, TILT_LIM);
    endfunction

    // Advance the filter state by one sample and return the expected result
    function automatic tilt_result_t step_filter(input logic signed [15:0] ax,
                                                 input logic signed [15:0] az,
                                                 input logic signed [15:0] rate);
        longint       k;
        longint       acc;
        longint       inc;
        longint       mix;
        tilt_result_t r;
        k   = (weight_k > K_ONE) ? 65536 : longint'(weight_k);
        acc = accel_tilt(ax, az);
        inc = (longint'(rate) * longint'(step_gain) + 32768) >>> 16;
        mix = k * (tilt_est + inc) + (65536 - k) * acc;
        tilt_est = clamp((mix + 32768) >>> 16, ANGLE_LO, ANGLE_HI);
        gyro_sum = clamp(gyro_sum + inc, ANGLE_LO, ANGLE_HI);
        r.filtered = tilt_est[ANGW-1:0];
        r.accel    = acc[AW-1:0];
        r.gyro     = gyro_sum[ANGW-1:0];
        return r;
    endfunction

    // Stall the result channel at random and check each accepted result
    always @(posedge clk)
    begin : result_check
        tilt_result_t want;
        if (out_valid === 1'b1 && out_ready)
        begin
            if (expected_q.size() == 0)
            begin
                $error("unexpected result item: filtered_angle %0d", filtered_angle);
                error_count++;
            end
            else
            begin
                want = expected_q.pop_front();
                if (filtered_angle !== want.filtered)
                begin
                    $error("filtered_angle: expected %0d, actual %0d",
                           want.filtered, filtered_angle);
                    error_count++;
                end
                if (accel_angle !== want.accel)
                begin
                    $error("accel_angle: expected %0d, actual %0d", want.accel, accel_angle);
                    error_count++;
                end
                if (gyro_tilt !== want.gyro)
                begin
                    $error("gyro_tilt: expected %0d, actual %0d", want.gyro, gyro_tilt);
                    error_count++;
                end
            end
        end
        out_ready <= ($urandom_range(99) >= out_stall_pct);
    end

    // Offer one sample after a random gap and record its prediction on acceptance
    task automatic send_sample(input logic signed [15:0] ax,
                               input logic signed [15:0] az,
                               input logic signed [15:0] rate);
        while ($urandom_range(99) < in_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        accel_x   <= ax;
        accel_z   <= az;
        gyro_rate <= rate;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        expected_q.push_back(step_filter(ax, az, rate));
    endtask

    // Drain the block, then write one register
    task automatic write_register(input tcf_reg_t idx, input logic [KW-1:0] value);
        in_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (LATENCY) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == REG_FILTER_K)
            weight_k = value;
        else
            step_gain = value[GAINW-1:0];
    endtask

    // Mostly full-range values, with extremes and values near zero mixed in
    function automatic logic signed [15:0] pick_field();
        logic signed [15:0] v;
        case ($urandom_range(9))
            0:       v = 16'sh8000;
            1:       v = 16'sh7FFF;
            2:       v = '0;
            3:       v = 16'($urandom_range(16)) - 16'd8;
            default: v = 16'($urandom());
        endcase
        return v;
    endfunction

    function automatic logic [KW-1:0] pick_weight();
        logic [KW-1:0] v;
        case ($urandom_range(5))
            0:       v = '0;
            1:       v = K_ONE;
            2:       v = '1;
            3:       v = KW'($urandom_range(131071));
            default: v = KW'($urandom_range(65536, 60000));
        endcase
        return v;
    endfunction

    // Items under the power-on register values
    task automatic test_power_on_defaults();
        send_sample(16'sd1000, 16'sd16000, 16'sd500);
        send_sample(-16'sd32768, 16'sd32767, 16'sd32767);
        send_sample(16'sd0, 16'sd0, -16'sd32768);
    endtask

    // Accel extremes in every quadrant, blend weight zero so the output follows the tilt
    task automatic test_tilt_extremes();
        write_register(REG_FILTER_K, '0);
        write_register(REG_GYRO_GAIN, KW'(65535));
        send_sample(16'sd0, 16'sd0, 16'sd0);
        send_sample(16'sd0, 16'sd32767, 16'sd32767);
        send_sample(16'sd32767, 16'sd0, -16'sd32768);
        send_sample(-16'sd32768, 16'sd0, 16'sd1);
        send_sample(16'sd0, -16'sd32768, -16'sd1);
        send_sample(16'sd1, -16'sd32768, 16'sd0);
        send_sample(-16'sd1, -16'sd32768, 16'sd0);
        send_sample(-16'sd32768, -16'sd32768, 16'sd32767);
        send_sample(16'sd32767, -16'sd32768, -16'sd32768);
        send_sample(16'sd32767, 16'sd32767, 16'sd100);
        send_sample(-16'sd32768, 16'sd32767, -16'sd100);
        send_sample(16'sd1, 16'sd1, 16'sd0);
        send_sample(-16'sd1, 16'sd1, 16'sd0);
        send_sample(16'sd1, 16'sd0, 16'sd0);
        send_sample(-16'sd1, -16'sd1, 16'sd0);
    endtask

    // Weight at one and above one, which must act as one
    task automatic test_weight_limits();
        write_register(REG_FILTER_K, K_ONE);
        send_sample(16'sd12000, -16'sd5000, 16'sd32767);
        send_sample(-16'sd12000, 16'sd5000, -16'sd20000);
        write_register(REG_FILTER_K, '1);
        send_sample(16'sd300, 16'sd16384, 16'sd32767);
        send_sample(16'sd300, 16'sd16384, -16'sd32768);
        write_register(REG_FILTER_K, K_ONE + 1'b1);
        send_sample(-16'sd8000, 16'sd8000, 16'sd4096);
    endtask

    // Random samples under two random register settings
    task automatic test_random_stream(input int count);
        for (int blk = 0; blk < 2; blk++)
        begin
            write_register(REG_FILTER_K, pick_weight());
            write_register(REG_GYRO_GAIN, KW'($urandom_range(65535)));
            repeat (count / 2) send_sample(pick_field(), pick_field(), pick_field());
        end
    endtask

    // Drive both angles into positive saturation, then back off it
    task automatic test_gyro_saturation();
        write_register(REG_FILTER_K, K_ONE);
        write_register(REG_GYRO_GAIN, KW'(65535));
        repeat (280)
            send_sample(pick_field(), pick_field(), 16'sd32767 - 16'($urandom_range(255)));
        repeat (40)
            send_sample(pick_field(), pick_field(), -16'sd32768 + 16'($urandom_range(255)));
    endtask

    initial
    begin
        in_gap_pct    = 38;
        out_stall_pct = 68;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_power_on_defaults();
        test_tilt_extremes();
        test_weight_limits();
        test_random_stream(90);

        in_gap_pct    = 68;
        out_stall_pct = 38;
        test_random_stream(90);

        in_gap_pct    = 0;
        out_stall_pct = 0;
        test_random_stream(90);
        test_gyro_saturation();

        // Drain, then give stray results time to show up
        in_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (2 * LATENCY) @(posedge clk);

        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
